FILE: design/assert_macros.svh
// Assertion macros used by the sequencer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define KSSQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define KSSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/kssq_pkg.sv
// Shared types, actuator bits, register indexes and step table of the station sequencer
package kssq_pkg;

  localparam int ActW   = 14;
  localparam int DwellW = 16;
  localparam int PhaseW = 3;
  localparam int CfgW   = 16;
  localparam int CfgAdW = 3;

  // Actuator mask bits
  localparam logic [ActW-1:0] A_CW      = 14'h0001;
  localparam logic [ActW-1:0] A_CCW     = 14'h0002;
  localparam logic [ActW-1:0] A_CONVEY  = 14'h0004;
  localparam logic [ActW-1:0] A_SAW     = 14'h0008;
  localparam logic [ActW-1:0] A_RETRACT = 14'h0010;
  localparam logic [ActW-1:0] A_EXTEND  = 14'h0020;
  localparam logic [ActW-1:0] A_TO_KILN = 14'h0040;
  localparam logic [ActW-1:0] A_TO_SAW  = 14'h0080;
  localparam logic [ActW-1:0] A_LAMP    = 14'h0100;
  localparam logic [ActW-1:0] A_COMPR   = 14'h0200;
  localparam logic [ActW-1:0] A_SUCTION = 14'h0400;
  localparam logic [ActW-1:0] A_LOWER   = 14'h0800;
  localparam logic [ActW-1:0] A_DOOR    = 14'h1000;
  localparam logic [ActW-1:0] A_EJECT   = 14'h2000;
  localparam logic [ActW-1:0] A_NONE    = 14'h0000;

  // Configuration register indexes
  localparam logic [CfgAdW-1:0] CFG_HEAT   = 3'd0;
  localparam logic [CfgAdW-1:0] CFG_SAW    = 3'd1;
  localparam logic [CfgAdW-1:0] CFG_EJECT  = 3'd2;
  localparam logic [CfgAdW-1:0] CFG_CONVEY = 3'd3;
  localparam logic [CfgAdW-1:0] CFG_SETTLE = 3'd4;

  // Register reset values in ticks
  localparam logic [CfgW-1:0] HEAT_RST   = 16'd3000;
  localparam logic [CfgW-1:0] SAW_RST    = 16'd5000;
  localparam logic [CfgW-1:0] EJECT_RST  = 16'd1000;
  localparam logic [CfgW-1:0] CONVEY_RST = 16'd3000;
  localparam logic [CfgW-1:0] SETTLE_RST = 16'd500;

  // Phase codes
  localparam logic [PhaseW-1:0] PH_HOME  = 3'd0;
  localparam logic [PhaseW-1:0] PH_WAIT  = 3'd1;
  localparam logic [PhaseW-1:0] PH_HEAT  = 3'd2;
  localparam logic [PhaseW-1:0] PH_XFER  = 3'd3;
  localparam logic [PhaseW-1:0] PH_CUT   = 3'd4;
  localparam logic [PhaseW-1:0] PH_CONV  = 3'd5;

  typedef enum logic [3:0] {
    S_HOME_OUT      = 4'd0,
    S_WAIT          = 4'd1,
    S_HEAT_IN       = 4'd2,
    S_HEAT_DWELL    = 4'd3,
    S_HEAT_OUT      = 4'd4,
    S_GRIP_KILN     = 4'd5,
    S_LOWER_DWELL   = 4'd6,
    S_SUCK_DWELL    = 4'd7,
    S_GRIP_SAW      = 4'd8,
    S_TURN_SUCTION  = 4'd9,
    S_RELEASE_DWELL = 4'd10,
    S_TURN_SAW      = 4'd11,
    S_SAW_DWELL     = 4'd12,
    S_TURN_CONV     = 4'd13,
    S_EJECT_DWELL   = 4'd14,
    S_CONVEY_DWELL  = 4'd15
  } step_t;

  // One tick's switch levels, oven_slide_in in bit 0
  typedef struct packed {
    logic table_at_conveyor;
    logic table_at_saw;
    logic table_at_suction;
    logic gripper_at_saw;
    logic gripper_at_kiln;
    logic kiln_barrier;
    logic oven_slide_out;
    logic oven_slide_in;
  } in_bits_t;

  typedef struct packed {
    step_t             step;
    logic [DwellW-1:0] dwell;
    logic [ActW-1:0]   act;
  } seq_state_t;

  typedef struct packed {
    logic [CfgW-1:0] heat_time;
    logic [CfgW-1:0] saw_time;
    logic [CfgW-1:0] eject_time;
    logic [CfgW-1:0] convey_time;
    logic [CfgW-1:0] settle_time;
  } cfg_t;

  // Clear the off bits, then set the on bits
  function automatic logic [ActW-1:0] set_bits(input logic [ActW-1:0] act,
                                               input logic [ActW-1:0] on,
                                               input logic [ActW-1:0] off);
    set_bits = (act & ~off) | on;
  endfunction

  function automatic logic [PhaseW-1:0] phase_of(input step_t s);
    case (s)
      S_HOME_OUT:                                   phase_of = PH_HOME;
      S_WAIT:                                       phase_of = PH_WAIT;
      S_HEAT_IN, S_HEAT_DWELL, S_HEAT_OUT:          phase_of = PH_HEAT;
      S_GRIP_KILN, S_LOWER_DWELL, S_SUCK_DWELL,
      S_GRIP_SAW, S_TURN_SUCTION, S_RELEASE_DWELL:  phase_of = PH_XFER;
      S_TURN_SAW, S_SAW_DWELL, S_TURN_CONV,
      S_EJECT_DWELL:                                phase_of = PH_CUT;
      S_CONVEY_DWELL:                               phase_of = PH_CONV;
      default:                                      phase_of = PH_HOME;
    endcase
  endfunction

endpackage

FILE: design/kssq_cfg.sv
// Dwell duration registers with write port
module kssq_cfg
  import kssq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CfgAdW-1:0] cfg_addr,
  input  logic [CfgW-1:0]   cfg_wdata,
  output cfg_t              cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write; drop writes to unknown indexes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_HEAT:   cfg_nxt.heat_time   = cfg_wdata;
        CFG_SAW:    cfg_nxt.saw_time    = cfg_wdata;
        CFG_EJECT:  cfg_nxt.eject_time  = cfg_wdata;
        CFG_CONVEY: cfg_nxt.convey_time = cfg_wdata;
        CFG_SETTLE: cfg_nxt.settle_time = cfg_wdata;
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.heat_time   <= HEAT_RST;
      cfg_r.saw_time    <= SAW_RST;
      cfg_r.eject_time  <= EJECT_RST;
      cfg_r.convey_time <= CONVEY_RST;
      cfg_r.settle_time <= SETTLE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: design/kssq_next.sv
// Next-step logic: one tick of the station sequence
module kssq_next
  import kssq_pkg::*;
(
  input  seq_state_t cur,
  input  in_bits_t   sw,
  input  cfg_t       cfg,
  output seq_state_t nxt
);

  logic [CfgW-1:0]   dur;
  logic [DwellW:0]   dw_inc;
  logic              dw_done;
  logic [DwellW-1:0] dw_cnt;

  // Pick the duration of the current dwell
  always_comb begin
    case (cur.step)
      S_HEAT_DWELL:   dur = cfg.heat_time;
      S_SAW_DWELL:    dur = cfg.saw_time;
      S_EJECT_DWELL:  dur = cfg.eject_time;
      S_CONVEY_DWELL: dur = cfg.convey_time;
      default:        dur = cfg.settle_time;
    endcase
  end

  // Count the tick; the dwell ends once the count reaches the duration
  assign dw_inc  = {1'b0, cur.dwell} + {{DwellW{1'b0}}, 1'b1};
  assign dw_done = dw_inc >= {1'b0, dur};
  assign dw_cnt  = dw_done ? '0 : dw_inc[DwellW-1:0];

  // Advance the sequence
  always_comb begin
    nxt = cur;
    case (cur.step)
      S_HOME_OUT: begin
        if (sw.oven_slide_out) begin
          nxt.act  = set_bits(cur.act, A_NONE, A_EXTEND | A_DOOR);
          nxt.step = S_WAIT;
        end else begin
          nxt.act = set_bits(cur.act, A_EXTEND | A_DOOR, A_RETRACT);
        end
      end
      S_WAIT: begin
        if (!sw.kiln_barrier) begin
          nxt.act  = set_bits(cur.act, A_LAMP | A_DOOR, A_NONE);
          nxt.step = S_HEAT_IN;
        end
      end
      S_HEAT_IN: begin
        if (sw.oven_slide_in) begin
          nxt.act   = set_bits(cur.act, A_NONE, A_RETRACT | A_DOOR);
          nxt.dwell = '0;
          nxt.step  = S_HEAT_DWELL;
        end else begin
          nxt.act = set_bits(cur.act, A_RETRACT, A_EXTEND);
        end
      end
      S_HEAT_DWELL: begin
        nxt.dwell = dw_cnt;
        if (dw_done) begin
          nxt.act  = set_bits(cur.act, A_DOOR, A_NONE);
          nxt.step = S_HEAT_OUT;
        end
      end
      S_HEAT_OUT: begin
        if (sw.oven_slide_out) begin
          nxt.act  = set_bits(cur.act, A_NONE, A_EXTEND | A_LAMP | A_DOOR);
          nxt.step = S_GRIP_KILN;
        end else begin
          nxt.act = set_bits(cur.act, A_EXTEND, A_RETRACT);
        end
      end
      S_GRIP_KILN: begin
        if (sw.gripper_at_kiln) begin
          nxt.act   = set_bits(cur.act, A_LOWER, A_TO_KILN);
          nxt.dwell = '0;
          nxt.step  = S_LOWER_DWELL;
        end else begin
          nxt.act = set_bits(cur.act, A_TO_KILN, A_TO_SAW);
        end
      end
      S_LOWER_DWELL: begin
        nxt.dwell = dw_cnt;
        if (dw_done) begin
          nxt.act  = set_bits(cur.act, A_SUCTION, A_NONE);
          nxt.step = S_SUCK_DWELL;
        end
      end
      S_SUCK_DWELL: begin
        nxt.dwell = dw_cnt;
        if (dw_done) begin
          nxt.act  = set_bits(cur.act, A_NONE, A_LOWER);
          nxt.step = S_GRIP_SAW;
        end
      end
      S_GRIP_SAW: begin
        if (sw.gripper_at_saw) begin
          nxt.act  = set_bits(cur.act, A_NONE, A_TO_SAW);
          nxt.step = S_TURN_SUCTION;
        end else begin
          nxt.act = set_bits(cur.act, A_TO_SAW, A_TO_KILN);
        end
      end
      S_TURN_SUCTION: begin
        if (sw.table_at_suction) begin
          nxt.act   = set_bits(cur.act, A_NONE, A_CCW | A_SUCTION);
          nxt.dwell = '0;
          nxt.step  = S_RELEASE_DWELL;
        end else begin
          nxt.act = set_bits(cur.act, A_CCW, A_CW);
        end
      end
      S_RELEASE_DWELL: begin
        nxt.dwell = dw_cnt;
        if (dw_done) begin
          nxt.step = S_TURN_SAW;
        end
      end
      S_TURN_SAW: begin
        if (sw.table_at_saw) begin
          nxt.act   = set_bits(cur.act, A_SAW, A_CW);
          nxt.dwell = '0;
          nxt.step  = S_SAW_DWELL;
        end else begin
          nxt.act = set_bits(cur.act, A_CW, A_CCW);
        end
      end
      S_SAW_DWELL: begin
        nxt.dwell = dw_cnt;
        if (dw_done) begin
          nxt.act  = set_bits(cur.act, A_NONE, A_SAW);
          nxt.step = S_TURN_CONV;
        end
      end
      S_TURN_CONV: begin
        if (sw.table_at_conveyor) begin
          nxt.act   = set_bits(cur.act, A_EJECT, A_CW);
          nxt.dwell = '0;
          nxt.step  = S_EJECT_DWELL;
        end else begin
          nxt.act = set_bits(cur.act, A_CW, A_CCW);
        end
      end
      S_EJECT_DWELL: begin
        nxt.dwell = dw_cnt;
        if (dw_done) begin
          nxt.act  = set_bits(cur.act, A_CONVEY, A_EJECT);
          nxt.step = S_CONVEY_DWELL;
        end
      end
      S_CONVEY_DWELL: begin
        nxt.dwell = dw_cnt;
        if (dw_done) begin
          nxt.act  = set_bits(cur.act, A_NONE, A_CONVEY);
          nxt.step = S_HOME_OUT;
        end
      end
      default: begin
        nxt.step  = S_HOME_OUT;
        nxt.dwell = '0;
      end
    endcase
    // Compressor stays on
    nxt.act = nxt.act | A_COMPR;
  end

endmodule

FILE: design/kiln_saw_station_sequencer_core.sv
// A tick word is held in the input register, then its result word in the result register.
// Throughput: one tick word per clock; the input register and the result register
// advance together whenever the result register is empty or being taken.
// Reset (rst_n low, synchronous): sequence back to the slide homing step, dwell
// count cleared, only the compressor driven, dwell durations to their defaults.
// Top level of the kiln and saw station sequencer
`include "assert_macros.svh"

module kiln_saw_station_sequencer_core
  import kssq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // in_tdata: oven_slide_in, oven_slide_out, kiln_barrier, gripper_at_kiln,
  //           gripper_at_saw, table_at_suction, table_at_saw, table_at_conveyor
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  // out_tdata: actuators [13:0], phase [16:14], zero [23:17]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,
  input  logic              cfg_we,
  input  logic [CfgAdW-1:0] cfg_addr,
  input  logic [CfgW-1:0]   cfg_wdata
);

  logic              s1_v_r;
  in_bits_t          s1_in_r;
  logic              out_v_r;
  logic [PhaseW-1:0] out_phase_r;
  seq_state_t        st_r;
  seq_state_t        st_nxt;
  cfg_t              cfg;
  logic              adv;
  logic              fire;
  logic              no_dwell;

  kssq_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  kssq_next u_next (
    .cur(st_r),
    .sw (s1_in_r),
    .cfg(cfg),
    .nxt(st_nxt)
  );

  // Result register frees when empty or taken; input register follows it
  assign adv       = !out_v_r || out_tready;
  assign fire      = s1_v_r && adv;
  assign in_tready = !s1_v_r || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      s1_in_r <= in_bits_t'(in_tdata);
    end
  end

  // Sequence state doubles as the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r    <= 1'b0;
      st_r.step  <= S_HOME_OUT;
      st_r.dwell <= '0;
      st_r.act   <= A_COMPR;
    end else begin
      if (adv) begin
        out_v_r <= s1_v_r;
      end
      if (fire) begin
        st_r <= st_nxt;
      end
    end
    if (fire) begin
      out_phase_r <= phase_of(st_nxt.step);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, out_phase_r, st_r.act};

  // Steps that never count dwell ticks
  assign no_dwell = st_r.step inside {S_HOME_OUT, S_WAIT, S_HEAT_IN, S_HEAT_OUT, S_GRIP_KILN,
                                      S_GRIP_SAW, S_TURN_SUCTION, S_TURN_SAW, S_TURN_CONV};

  `KSSQ_ASSERT_NOW(a_compr_on, 1'b1, (st_r.act & A_COMPR) == A_COMPR, "compressor bit dropped")
  `KSSQ_ASSERT_NOW(a_dwell_idle, no_dwell, st_r.dwell == '0, "dwell count live outside a dwell")
  `KSSQ_ASSERT_NOW(a_phase_range, out_tvalid, out_tdata[16:14] <= PH_CONV, "phase out of range")
  `KSSQ_ASSERT_NEXT(a_fire_out, fire, out_tvalid, "computed word not presented")
  `KSSQ_ASSERT_NOW(a_stall_full, !in_tready, s1_v_r && out_v_r && !out_tready, "stall, pipe not full")

endmodule

FILE: tb/sv/kiln_saw_station_sequencer_core_tb.sv
// Self-checking testbench for the kiln and saw station sequencer core
`timescale 1ns / 100ps

module kiln_saw_station_sequencer_core_tb;
  import kssq_pkg::*;

  // Spare register indexes, decoded by nothing
  localparam logic [CfgAdW-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CfgAdW-1:0] CFG_SPARE_HI = 3'd7;

  // One result word: actuator mask and phase
  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [ActW-1:0]   act;
  } station_word_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = 8'h00;   // switch levels, oven_slide_in in bit 0
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [23:0]       out_tdata;          // actuators [13:0], phase [16:14], zero [23:17]
  logic              cfg_we = 1'b0;
  logic [CfgAdW-1:0] cfg_addr = CFG_HEAT;
  logic [CfgW-1:0]   cfg_wdata = '0;

  // Station model state and durations
  step_t           seq_step = S_HOME_OUT;
  logic [DwellW-1:0] dwell_ticks = '0;
  logic [ActW-1:0] act_mask = A_COMPR;
  logic [CfgW-1:0] dur_heat = HEAT_RST;
  logic [CfgW-1:0] dur_saw = SAW_RST;
  logic [CfgW-1:0] dur_eject = EJECT_RST;
  logic [CfgW-1:0] dur_convey = CONVEY_RST;
  logic [CfgW-1:0] dur_settle = SETTLE_RST;

  station_word_t pending_words[$];
  int err_count = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;

  kiln_saw_station_sequencer_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Receiver: long hold-off when asked, else ready, with random stalls when a stall percentage is set
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_pct == 0) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
  endtask

  // Compare each taken word with the oldest prediction
  always @(posedge clk) begin
    station_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", 32'(out_tdata), 32'd0);
      end else begin
        want = pending_words.pop_front();
        if (out_tdata[13:0] !== want.act)
          report_mismatch("actuators", 32'(out_tdata[13:0]), 32'(want.act));
        if (out_tdata[16:14] !== want.phase)
          report_mismatch("phase", 32'(out_tdata[16:14]), 32'(want.phase));
        if (out_tdata[23:17] !== 7'd0)
          report_mismatch("pad bits", 32'(out_tdata[23:17]), 32'd0);
      end
    end
  end

  function automatic logic [ActW-1:0] outputs_with(input logic [ActW-1:0] on,
                                                   input logic [ActW-1:0] off);
    return (act_mask & ~off) | on;
  endfunction

  // Count one dwell tick; true when the dwell ends now
  function automatic bit dwell_ends(input logic [CfgW-1:0] limit);
    logic [DwellW:0] nxt;
    nxt = {1'b0, dwell_ticks} + {{DwellW{1'b0}}, 1'b1};
    if (nxt >= {1'b0, limit}) begin
      dwell_ticks = '0;
      return 1'b1;
    end
    dwell_ticks = nxt[DwellW-1:0];
    return 1'b0;
  endfunction

  function automatic logic [PhaseW-1:0] phase_for(input step_t s);
    case (s)
      S_HOME_OUT:                                 return PH_HOME;
      S_WAIT:                                     return PH_WAIT;
      S_HEAT_IN, S_HEAT_DWELL, S_HEAT_OUT:        return PH_HEAT;
      S_TURN_SAW, S_SAW_DWELL, S_TURN_CONV,
      S_EJECT_DWELL:                              return PH_CUT;
      S_CONVEY_DWELL:                             return PH_CONV;
      default:                                    return PH_XFER;
    endcase
  endfunction

  // Advance the station by one tick and queue the word it gives
  function automatic void step_station(input in_bits_t t);
    case (seq_step)
      S_HOME_OUT:
        if (t.oven_slide_out) begin
          act_mask = outputs_with(A_NONE, A_EXTEND | A_DOOR);
          seq_step = S_WAIT;
        end else act_mask = outputs_with(A_EXTEND | A_DOOR, A_RETRACT);
      S_WAIT:
        if (!t.kiln_barrier) begin
          act_mask = outputs_with(A_LAMP | A_DOOR, A_NONE);
          seq_step = S_HEAT_IN;
        end
      S_HEAT_IN:
        if (t.oven_slide_in) begin
          act_mask = outputs_with(A_NONE, A_RETRACT | A_DOOR);
          dwell_ticks = '0;
          seq_step = S_HEAT_DWELL;
        end else act_mask = outputs_with(A_RETRACT, A_EXTEND);
      S_HEAT_DWELL:
        if (dwell_ends(dur_heat)) begin
          act_mask = outputs_with(A_DOOR, A_NONE);
          seq_step = S_HEAT_OUT;
        end
      S_HEAT_OUT:
        if (t.oven_slide_out) begin
          act_mask = outputs_with(A_NONE, A_EXTEND | A_LAMP | A_DOOR);
          seq_step = S_GRIP_KILN;
        end else act_mask = outputs_with(A_EXTEND, A_RETRACT);
      S_GRIP_KILN:
        if (t.gripper_at_kiln) begin
          act_mask = outputs_with(A_LOWER, A_TO_KILN);
          dwell_ticks = '0;
          seq_step = S_LOWER_DWELL;
        end else act_mask = outputs_with(A_TO_KILN, A_TO_SAW);
      S_LOWER_DWELL:
        if (dwell_ends(dur_settle)) begin
          act_mask = outputs_with(A_SUCTION, A_NONE);
          seq_step = S_SUCK_DWELL;
        end
      S_SUCK_DWELL:
        if (dwell_ends(dur_settle)) begin
          act_mask = outputs_with(A_NONE, A_LOWER);
          seq_step = S_GRIP_SAW;
        end
      S_GRIP_SAW:
        if (t.gripper_at_saw) begin
          act_mask = outputs_with(A_NONE, A_TO_SAW);
          seq_step = S_TURN_SUCTION;
        end else act_mask = outputs_with(A_TO_SAW, A_TO_KILN);
      S_TURN_SUCTION:
        if (t.table_at_suction) begin
          act_mask = outputs_with(A_NONE, A_CCW | A_SUCTION);
          dwell_ticks = '0;
          seq_step = S_RELEASE_DWELL;
        end else act_mask = outputs_with(A_CCW, A_CW);
      S_RELEASE_DWELL:
        if (dwell_ends(dur_settle)) seq_step = S_TURN_SAW;
      S_TURN_SAW:
        if (t.table_at_saw) begin
          act_mask = outputs_with(A_SAW, A_CW);
          dwell_ticks = '0;
          seq_step = S_SAW_DWELL;
        end else act_mask = outputs_with(A_CW, A_CCW);
      S_SAW_DWELL:
        if (dwell_ends(dur_saw)) begin
          act_mask = outputs_with(A_NONE, A_SAW);
          seq_step = S_TURN_CONV;
        end
      S_TURN_CONV:
        if (t.table_at_conveyor) begin
          act_mask = outputs_with(A_EJECT, A_CW);
          dwell_ticks = '0;
          seq_step = S_EJECT_DWELL;
        end else act_mask = outputs_with(A_CW, A_CCW);
      S_EJECT_DWELL:
        if (dwell_ends(dur_eject)) begin
          act_mask = outputs_with(A_CONVEY, A_EJECT);
          seq_step = S_CONVEY_DWELL;
        end
      default:
        if (dwell_ends(dur_convey)) begin
          act_mask = outputs_with(A_NONE, A_CONVEY);
          seq_step = S_HOME_OUT;
        end
    endcase
    act_mask = act_mask | A_COMPR;
    pending_words.push_back('{phase: phase_for(seq_step), act: act_mask});
  endfunction

  function automatic void store_reg(input logic [CfgAdW-1:0] a, input logic [CfgW-1:0] d);
    case (a)
      CFG_HEAT:   dur_heat = d;
      CFG_SAW:    dur_saw = d;
      CFG_EJECT:  dur_eject = d;
      CFG_CONVEY: dur_convey = d;
      CFG_SETTLE: dur_settle = d;
      default:    ;
    endcase
  endfunction

  // Write all five durations, then one spare index that must be ignored
  task automatic load_durations(input logic [CfgW-1:0] heat, input logic [CfgW-1:0] saw,
                                input logic [CfgW-1:0] eject, input logic [CfgW-1:0] convey,
                                input logic [CfgW-1:0] settle);
    logic [CfgW-1:0]   vals [6];
    logic [CfgAdW-1:0] idx [6];
    vals = '{heat, saw, eject, convey, settle, CfgW'($urandom)};
    idx = '{CFG_HEAT, CFG_SAW, CFG_EJECT, CFG_CONVEY, CFG_SETTLE,
            CfgAdW'($urandom_range(CFG_SPARE_HI, CFG_SPARE_LO))};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= idx[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      store_reg(idx[i], vals[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one tick word, hold it until taken, then maybe idle
  task automatic send_tick(input in_bits_t t);
    in_tvalid <= 1'b1;
    in_tdata <= t;
    do @(posedge clk); while (!in_tready);
    step_station(t);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
  endtask

  // Stop offering and hold until every predicted word has come back
  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Random switch levels, mostly steering the switch the current step waits on
  function automatic in_bits_t shaped_tick();
    in_bits_t t;
    bit       hit;
    t = in_bits_t'(8'($urandom));
    hit = ($urandom_range(99) < 40);
    if ($urandom_range(99) < 85) begin
      case (seq_step)
        S_HOME_OUT, S_HEAT_OUT: t.oven_slide_out = hit;
        S_WAIT:                 t.kiln_barrier = !hit;
        S_HEAT_IN:              t.oven_slide_in = hit;
        S_GRIP_KILN:            t.gripper_at_kiln = hit;
        S_GRIP_SAW:             t.gripper_at_saw = hit;
        S_TURN_SUCTION:         t.table_at_suction = hit;
        S_TURN_SAW:             t.table_at_saw = hit;
        S_TURN_CONV:            t.table_at_conveyor = hit;
        default:                ;
      endcase
    end
    return t;
  endfunction

  function automatic logic [CfgW-1:0] pick_duration(input int longest);
    if ($urandom_range(9) == 0) return '0;
    return CfgW'($urandom_range(longest, 1));
  endfunction

  // Two halves of shaped random ticks, fresh durations for each
  task automatic run_shaped_ticks(input int count, input int snd_pct, input int rcv_pct,
                                  input int longest);
    gap_pct = snd_pct;
    stall_pct = rcv_pct;
    for (int half = 0; half < 2; half++) begin
      load_durations(pick_duration(longest), pick_duration(longest), pick_duration(longest),
                     pick_duration(longest), pick_duration(longest));
      for (int n = 0; n < count / 2; n++) send_tick(shaped_tick());
      wait_results_done();
    end
  endtask

  // Reset durations: home, wait for a part, slide in, start the long heat dwell
  task automatic test_reset_walk();
    in_bits_t seq [8];
    seq = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00};
    gap_pct = 0;
    stall_pct = 0;
    foreach (seq[i]) send_tick(seq[i]);
    wait_results_done();
  endtask

  // Shorten heat below the count reached, then walk every step with switches closed
  task automatic test_closed_switches();
    load_durations(16'd1, 16'd0, 16'd1, 16'd0, 16'd0);
    repeat (16) send_tick(in_bits_t'(8'hFB));
    wait_results_done();
  endtask

  // Longest durations stall in a dwell; then cut them below the count
  task automatic test_long_durations();
    gap_pct = 0;
    stall_pct = 0;
    load_durations(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (60) send_tick(shaped_tick());
    wait_results_done();
    load_durations(16'd2, 16'd3, 16'd1, 16'd2, 16'd1);
    repeat (40) send_tick(shaped_tick());
    wait_results_done();
  endtask

  // Receiver holds off while the sender keeps pushing; then sender pauses
  task automatic test_backpressure();
    gap_pct = 0;
    stall_pct = 0;
    load_durations(16'd3, 16'd2, 16'd1, 16'd2, 16'd1);
    hold_req = 300;
    repeat (60) send_tick(shaped_tick());
    wait_results_done();
    repeat (20) send_tick(shaped_tick());
    wait_results_done();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_walk();
    test_closed_switches();
    test_long_durations();
    run_shaped_ticks(330, 0, 0, 5);
    run_shaped_ticks(320, 82, 0, 12);
    run_shaped_ticks(320, 0, 82, 3);
    run_shaped_ticks(320, 28, 28, 20);
    test_backpressure();
    stall_pct = 0;
    wait_results_done();
    repeat (6) @(posedge clk);
    if (err_count == 0) begin
      $display("** kiln_saw_station_sequencer_core: PASSED **");
    end else begin
      $display("** kiln_saw_station_sequencer_core: FAILED **");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #5_000_000;
    $display("** kiln_saw_station_sequencer_core: FAILED **");
    $finish;
  end

endmodule
